### rtl/assert_macros.svh
// Assertion macros used by the checker file of the frame rate block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define FRM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication that must hold from the cycle after the antecedent.
`define FRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	`FRM_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

### rtl/frm_pkg.sv
// Package with the widths, constants and control structs of the frame rate block.
`timescale 1ns / 1ps

package frm_pkg;

	// Number of frame durations averaged.
	localparam int WINDOW    = 100;
	localparam int TICK_W    = 16;
	localparam int RATE_W    = 25;
	localparam int FRAC_BITS = 8;
	localparam int MS_PER_S  = 1000;

	// Ring index and running sum widths.
	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W = $clog2(WINDOW * ((1 << TICK_W) - 1) + 1);

	// Dividend of the rate: milliseconds per second times window, in Q.8.
	localparam logic [63:0] NUM_VAL = 64'(MS_PER_S * WINDOW) << FRAC_BITS;
	localparam int NUM_W = $clog2(NUM_VAL + 64'd1);

	// Quotient compare width and divider step counter width.
	localparam int QX_W  = (NUM_W > RATE_W) ? NUM_W : RATE_W;
	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	localparam logic [RATE_W-1:0] RATE_MAX = '1;

	typedef struct packed {
		logic accept;    // input transaction taken: capture tick, read ring
		logic update;    // update ring, sum and index; load the divider
		logic step;      // one restoring division step
		logic out_load;  // move the result into the output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_last;  // the current division step is the final one
	} dp_status_t;

endpackage

### rtl/frm_in_if.sv
// Input channel interface carrying one frame duration per transaction.
`timescale 1ns / 1ps

interface frm_in_if;
	logic                      valid;
	logic                      ready;
	logic [frm_pkg::TICK_W-1:0] tick_ms;

	modport source (output valid, output tick_ms, input ready);
	modport sink   (input valid, input tick_ms, output ready);
endinterface

### rtl/frm_out_if.sv
// Output channel interface carrying one frame rate result per transaction.
`timescale 1ns / 1ps

interface frm_out_if;
	logic                      valid;
	logic                      ready;
	logic [frm_pkg::RATE_W-1:0] rate_q8;
	logic                      sum_zero;

	modport source (output valid, output rate_q8, output sum_zero, input ready);
	modport sink   (input valid, input rate_q8, input sum_zero, output ready);
endinterface

### rtl/frm_ctrl.sv
// Controller state machine that sequences update, division and result hand-off.
`timescale 1ns / 1ps

module frm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  frm_pkg::dp_status_t   status,
	output frm_pkg::ctrl_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_UPDATE = 2'd1;
	localparam logic [1:0] ST_DIV    = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	assign cmd.accept   = in_valid && in_ready;
	assign cmd.update   = (state_q == ST_UPDATE);
	assign cmd.step     = (state_q == ST_DIV);
	assign cmd.out_load = (state_q == ST_DONE) && out_free;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept) state_next = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_next = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_last) state_next = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/frm_dp.sv
// Datapath with the sample ring, running sum, write index, serial divider and result register.
`timescale 1ns / 1ps

module frm_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  frm_pkg::ctrl_cmd_t          cmd,
	input  logic [frm_pkg::TICK_W-1:0]  tick_ms,
	output frm_pkg::dp_status_t         status,
	output logic [frm_pkg::RATE_W-1:0]  rate_q8,
	output logic                        sum_zero
);

	// Sample ring; an entry counts as zero until the index has wrapped once.
	logic [frm_pkg::TICK_W-1:0] ring_mem [frm_pkg::WINDOW];
	logic [frm_pkg::TICK_W-1:0] ring_rd_q;
	logic [frm_pkg::TICK_W-1:0] tick_q;
	logic [frm_pkg::IDX_W-1:0]  idx_q;
	logic                       wrapped_q;
	logic [frm_pkg::SUM_W-1:0]  sum_q;

	logic [frm_pkg::TICK_W-1:0] old_sample;
	logic [frm_pkg::SUM_W-1:0]  sum_next;
	logic                       idx_last;

	// Restoring divider: quo_q shifts the dividend out and the quotient in.
	logic [frm_pkg::NUM_W-1:0]  quo_q;
	logic [frm_pkg::SUM_W-1:0]  rem_q;
	logic [frm_pkg::CNT_W-1:0]  cnt_q;
	logic [frm_pkg::SUM_W:0]    rem_shift;
	logic [frm_pkg::SUM_W:0]    div_ext;
	logic                       q_bit;
	logic [frm_pkg::SUM_W:0]    rem_diff;

	logic [frm_pkg::QX_W-1:0]   quo_ext;
	logic [frm_pkg::RATE_W-1:0] rate_sat;
	logic [frm_pkg::RATE_W-1:0] rate_q;
	logic                       zero_q;

	assign old_sample = wrapped_q ? ring_rd_q : '0;
	assign sum_next   = sum_q - frm_pkg::SUM_W'(old_sample) + frm_pkg::SUM_W'(tick_q);
	assign idx_last   = (idx_q == frm_pkg::IDX_W'(frm_pkg::WINDOW - 1));

	assign rem_shift = {rem_q, quo_q[frm_pkg::NUM_W-1]};
	assign div_ext   = {1'b0, sum_q};
	assign q_bit     = (rem_shift >= div_ext);
	assign rem_diff  = rem_shift - div_ext;

	assign status.div_last = (cnt_q == '0);

	assign quo_ext  = frm_pkg::QX_W'(quo_q);
	assign rate_sat = (quo_ext > frm_pkg::QX_W'(frm_pkg::RATE_MAX)) ?
		frm_pkg::RATE_MAX : quo_ext[frm_pkg::RATE_W-1:0];

	assign rate_q8  = rate_q;
	assign sum_zero = zero_q;

	always_ff @(posedge clk) begin
		if (cmd.update) ring_mem[idx_q] <= tick_q;
		if (cmd.accept) ring_rd_q <= ring_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
		end else if (cmd.update) begin
			sum_q <= sum_next;
			if (idx_last) begin
				idx_q     <= '0;
				wrapped_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) tick_q <= tick_ms;
		if (cmd.update) begin
			quo_q <= frm_pkg::NUM_VAL[frm_pkg::NUM_W-1:0];
			rem_q <= '0;
			cnt_q <= frm_pkg::CNT_W'(frm_pkg::NUM_W - 1);
		end else if (cmd.step) begin
			quo_q <= {quo_q[frm_pkg::NUM_W-2:0], q_bit};
			rem_q <= q_bit ? rem_diff[frm_pkg::SUM_W-1:0] : rem_shift[frm_pkg::SUM_W-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.out_load) begin
			zero_q <= (sum_q == '0);
			rate_q <= (sum_q == '0) ? '0 : rate_sat;
		end
	end

endmodule

### rtl/frame_rate_moving_average.sv
// Top level of the moving-average frame rate meter.
//
//   channel  | modport | payload                      | transfers when
//   ---------+---------+------------------------------+-------------------
//   sample   | sink    | tick_ms[15:0]                | valid && ready
//   result   | source  | rate_q8[24:0], sum_zero      | valid && ready
//
// A transaction runs through these steps before the next one can be
// taken: the ring read on acceptance, the sum and ring update, the
// bit-serial restoring divider (one quotient bit per cycle), and the load
// of the output register. The divider length follows the width of the dividend.
// Reset is asynchronous and active low; it clears the sum, index and control.
// A stalled result waits in the output register while the next input is taken.
`timescale 1ns / 1ps

module frame_rate_moving_average (
	input  logic      clk,
	input  logic      arst_n,
	frm_in_if.sink    sample,
	frm_out_if.source result
);

	// The controller only sequences; all arithmetic and storage sit in the
	// datapath, and the two talk through the command and status structs.
	frm_pkg::ctrl_cmd_t  cmd;
	frm_pkg::dp_status_t status;

	// The ring is never cleared explicitly. Because slots are overwritten in
	// order, a slot holds a real sample exactly when the index has wrapped at
	// least once, so the datapath substitutes zero before the first wrap.
	frm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The quotient is computed even for a zero sum; the output register then
	// reports a rate of zero with the sum_zero flag set.
	frm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.tick_ms  (sample.tick_ms),
		.status   (status),
		.rate_q8  (result.rate_q8),
		.sum_zero (result.sum_zero)
	);

endmodule

### rtl/frm_chk.sv
// Port-level checker for the frame rate meter and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frm_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [frm_pkg::RATE_W-1:0] rate_q8,
	input logic                       sum_zero
);

	`FRM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(rate_q8) && $stable(sum_zero), "stalled result changed")
	`FRM_ASSERT(a_zero_rate, clk, arst_n, out_valid && sum_zero |-> rate_q8 == '0, "zero sum with nonzero rate")
	`FRM_ASSERT(a_rate_nonzero, clk, arst_n, out_valid && !sum_zero |-> rate_q8 != '0, "nonzero sum gave zero rate")
	`FRM_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready, "input taken while busy")
	`FRM_ASSERT(a_no_instant, clk, arst_n, $rose(out_valid) |-> !$past(in_valid && in_ready), "result right after input")

endmodule

bind frame_rate_moving_average frm_chk u_frm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.rate_q8   (result.rate_q8),
	.sum_zero  (result.sum_zero)
);

### tb/testbench.sv
// Self-checking testbench for the moving-average frame rate meter.
`timescale 1ns / 1ps

// The bench streams frame durations into the meter and checks every frame
// rate that comes back. It keeps its own copy of the duration history, which
// holds the last WINDOW durations, their running sum and the slot to overwrite.
// From that copy it computes the expected rate for each accepted sample.
// A short directed list comes first. It covers the warm-up with an empty
// window, a sum of one that gives the peak rate, the largest durations and
// single-bit patterns. Random segments of different character follow: full
// range, typical frame times, tiny durations, runs of all-zero durations
// long enough to empty the window again, near-maximum durations and single
// set bits. Both channels idle at random. Twice the result side stops
// accepting for a long stretch while samples keep coming, so the meter backs
// up. Now and then the sample side waits until every result is home.
module testbench;

	localparam int CLK_HALF_NS   = 2;
	localparam int ITEMS_TOTAL   = 2000;
	localparam int HOLD_CYCLES   = 600;
	localparam int HOLD_FIRST    = 400;
	localparam int HOLD_SPACING  = 900;
	localparam int SETTLE_CYCLES = 64;
	localparam int REPORT_LIMIT  = 10;
	localparam logic [frm_pkg::RATE_W-1:0] PEAK_RATE = frm_pkg::RATE_W'(
		frm_pkg::MS_PER_S * frm_pkg::WINDOW * (1 << frm_pkg::FRAC_BITS));

	// Segment kinds of the random stimulus.
	typedef enum int {
		SEG_FULL_RANGE,
		SEG_TYPICAL,
		SEG_TINY,
		SEG_ZERO_RUN,
		SEG_NEAR_MAX,
		SEG_ONE_HOT,
		SEG_KIND_COUNT
	} seg_kind_t;

	typedef struct packed {
		logic [frm_pkg::RATE_W-1:0] rate_q8;
		logic                       sum_zero;
	} rate_result_t;

	// One planned sample; drain makes the sender wait for all results first.
	typedef struct {
		logic [frm_pkg::TICK_W-1:0] tick;
		bit                         drain;
	} tick_plan_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	frm_in_if  sample ();
	frm_out_if result ();

	frame_rate_moving_average u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	// The bench's own copy of the meter state. The history is cleared once
	// at time zero, matching the ring, whose slots count as zero until the first wrap.
	logic [frm_pkg::TICK_W-1:0] hist_ticks [frm_pkg::WINDOW];
	longint unsigned            hist_sum = 0;
	int                         hist_pos = 0;

	tick_plan_t   tick_plan_q [$];
	rate_result_t rate_expect_q [$];

	// Transaction counters. Only nonblocking updates, so any process reading
	// them at a clock edge sees the values from before that edge.
	int sent_cnt = 0;
	int done_cnt = 0;

	int err_cnt   = 0;
	int zero_seen = 0;
	int peak_seen = 0;

	int rx_hold_left = 0;
	int next_hold_at = HOLD_FIRST;
	int tx_gap       = 0;
	int rx_gap       = 0;
	bit tx_calm      = 1'b0;
	bit rx_calm      = 1'b0;

	// Push one duration into the history and work out the rate the meter
	// must report: the window total divided into 1000 * WINDOW in Q.8,
	// rounded down, with a flag and a zero rate when the window sums to 0.
	function automatic rate_result_t predict_rate(input logic [frm_pkg::TICK_W-1:0] tick);
		rate_result_t    res;
		longint unsigned dividend;
		longint unsigned quot;
		dividend = longint'(frm_pkg::MS_PER_S) * longint'(frm_pkg::WINDOW) *
			longint'(1 << frm_pkg::FRAC_BITS);
		if (hist_pos >= frm_pkg::WINDOW)
			hist_pos = 0;
		hist_sum = hist_sum - hist_ticks[hist_pos] + tick;
		hist_ticks[hist_pos] = tick;
		hist_pos = (hist_pos + 1 >= frm_pkg::WINDOW) ? 0 : hist_pos + 1;
		res.sum_zero = (hist_sum == 0);
		res.rate_q8  = '0;
		if (hist_sum != 0) begin
			quot = dividend / hist_sum;
			res.rate_q8 = (quot > longint'(frm_pkg::RATE_MAX)) ?
				frm_pkg::RATE_MAX : quot[frm_pkg::RATE_W-1:0];
		end
		return res;
	endfunction

	// Idle length: mostly a few cycles, sometimes longer than one division.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 4);
		else if (r < 92)
			return $urandom_range(5, 20);
		else
			return $urandom_range(30, 90);
	endfunction

	// Sample driver. A presented duration stays on the bus until it is taken.
	// A planned sample with the drain mark is held back until the result
	// count has caught up with the sample count. The cycle right after an
	// acceptance never counts as drained, because the sample counter still
	// lags by one there.
	always @(posedge clk) begin : sample_driver
		logic       took;
		tick_plan_t next_item;
		took = sample.valid && sample.ready;
		if (!arst_n) begin
			sample.valid <= 1'b0;
		end else begin
			if (took) begin
				rate_expect_q.push_back(predict_rate(sample.tick_ms));
				sent_cnt <= sent_cnt + 1;
				if (!tx_calm && $urandom_range(0, 1) == 1)
					tx_gap = pick_gap();
				if ($urandom_range(0, 149) == 0)
					tx_calm = !tx_calm;
			end
			if (sample.valid && !took) begin
				// Still waiting for the meter to take the current sample.
			end else if (tx_gap > 0) begin
				tx_gap--;
				sample.valid <= 1'b0;
			end else if (tick_plan_q.size() == 0) begin
				sample.valid <= 1'b0;
			end else if (tick_plan_q[0].drain && (took || sent_cnt != done_cnt)) begin
				sample.valid <= 1'b0;
			end else begin
				next_item = tick_plan_q.pop_front();
				sample.valid   <= 1'b1;
				sample.tick_ms <= next_item.tick;
			end
		end
	end

	// Long hold-off of the result side, counted here so the ready driver
	// only has to look at the remaining count.
	always @(posedge clk) begin : result_hold_timer
		if (!arst_n) begin
			rx_hold_left <= 0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end else if (sent_cnt >= next_hold_at) begin
			rx_hold_left <= HOLD_CYCLES;
			next_hold_at <= next_hold_at + HOLD_SPACING;
		end
	end

	// Ready driver for the result channel with short and long random stalls.
	always @(posedge clk) begin : result_ready_driver
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			result.ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
			if (!rx_calm && $urandom_range(0, 7) == 0)
				rx_gap = pick_gap();
		end
		if ($urandom_range(0, 499) == 0)
			rx_calm = !rx_calm;
	end

	// Result monitor: each accepted rate is compared with the oldest
	// expectation. Only the first few mismatches are printed in full.
	always @(posedge clk) begin : result_monitor
		rate_result_t want;
		if (arst_n && result.valid && result.ready) begin
			done_cnt <= done_cnt + 1;
			if (rate_expect_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= REPORT_LIMIT)
					$display("%0t: result with no sample pending: rate_q8=%0d sum_zero=%0b",
						$realtime, result.rate_q8, result.sum_zero);
			end else begin
				want = rate_expect_q.pop_front();
				if (result.rate_q8 !== want.rate_q8 || result.sum_zero !== want.sum_zero) begin
					err_cnt++;
					if (err_cnt <= REPORT_LIMIT)
						$display({"%0t: result %0d: expected rate_q8=%0d sum_zero=%0b, ",
							"got rate_q8=%0d sum_zero=%0b"},
							$realtime, done_cnt, want.rate_q8, want.sum_zero,
							result.rate_q8, result.sum_zero);
				end
				if (want.sum_zero)
					zero_seen++;
				if (want.rate_q8 == PEAK_RATE)
					peak_seen++;
			end
		end
	end

	// Run control: build the whole plan, release reset, wait for the last
	// result, let the meter settle, then report.
	initial begin : run_control
		logic [frm_pkg::TICK_W-1:0] directed_ticks [$];
		tick_plan_t                 step;
		seg_kind_t                  seg_kind;
		int                         seg_len;
		bit                         drain_next;

		sample.valid   = 1'b0;
		sample.tick_ms = '0;
		result.ready   = 1'b0;
		for (int i = 0; i < frm_pkg::WINDOW; i++)
			hist_ticks[i] = '0;

		// Empty window first, then a window sum of one (the peak rate), the
		// largest durations, alternating and single-bit patterns.
		directed_ticks = '{16'd0, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'h8000,
			16'h7FFF, 16'h5555, 16'hAAAA, 16'd16, 16'd33, 16'd17, 16'd1000,
			16'd2, 16'hFFFE, 16'h0001, 16'h00FF, 16'hFF00};
		foreach (directed_ticks[i]) begin
			step.tick  = directed_ticks[i];
			step.drain = 1'b0;
			tick_plan_q.push_back(step);
		end

		// Random segments. The first sample of some segments waits until
		// every earlier result has come back.
		drain_next = 1'b1;
		while (tick_plan_q.size() < ITEMS_TOTAL) begin
			seg_kind = seg_kind_t'($urandom_range(0, SEG_KIND_COUNT - 1));
			case (seg_kind)
				SEG_ZERO_RUN: seg_len = frm_pkg::WINDOW + $urandom_range(0, 10);
				SEG_NEAR_MAX: seg_len = frm_pkg::WINDOW + $urandom_range(0, 20);
				SEG_TINY:     seg_len = $urandom_range(20, 100);
				SEG_ONE_HOT:  seg_len = $urandom_range(10, 40);
				default:      seg_len = $urandom_range(20, 150);
			endcase
			for (int i = 0; i < seg_len; i++) begin
				case (seg_kind)
					SEG_FULL_RANGE: step.tick = frm_pkg::TICK_W'($urandom_range(0, 16'hFFFF));
					SEG_TYPICAL:    step.tick = frm_pkg::TICK_W'($urandom_range(10, 40));
					SEG_TINY:       step.tick = frm_pkg::TICK_W'($urandom_range(0, 3));
					SEG_ZERO_RUN:   step.tick = '0;
					SEG_NEAR_MAX:   step.tick = frm_pkg::TICK_W'($urandom_range(60000, 16'hFFFF));
					default:        step.tick = frm_pkg::TICK_W'(1) <<
						$urandom_range(0, frm_pkg::TICK_W - 1);
				endcase
				step.drain = drain_next;
				drain_next = 1'b0;
				tick_plan_q.push_back(step);
			end
			// After an emptied window a lone one gives the peak rate until it
			// leaves the window again.
			if (seg_kind == SEG_ZERO_RUN && $urandom_range(0, 1) == 1) begin
				step.tick  = 16'd1;
				step.drain = 1'b0;
				tick_plan_q.push_back(step);
				repeat ($urandom_range(0, 30)) begin
					step.tick = '0;
					tick_plan_q.push_back(step);
				end
			end
			drain_next = ($urandom_range(0, 3) == 0);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (tick_plan_q.size() != 0 || sample.valid || sent_cnt != done_cnt)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Streamed %0d frame durations and checked %0d rates, %0d mismatching.",
			sent_cnt, done_cnt, err_cnt);
		$display("Empty-window results: %0d, peak-rate results: %0d.", zero_seen, peak_seen);
		if (err_cnt == 0 && rate_expect_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin : watchdog
		#8_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
